### rtl/hfd_pkg.sv
// Shared types, constants and the frame classifier for the HTTP/3 deframer.
// No dependencies; every other file imports this package.
package hfd_pkg;

	localparam int VAL_W      = 62;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int CNT_W      = 3;

	// result kinds
	localparam logic RK_HEADER  = 1'b0;
	localparam logic RK_PAYLOAD = 1'b1;

	// frame type codes that the classifier recognises; the four HTTP/2 codes share the reserved class
	localparam logic [3:0] FT_DATA         = 4'h0;
	localparam logic [3:0] FT_HEADERS      = 4'h1;
	localparam logic [3:0] FT_H2_PRIORITY  = 4'h2;
	localparam logic [3:0] FT_CANCEL_PUSH  = 4'h3;
	localparam logic [3:0] FT_SETTINGS     = 4'h4;
	localparam logic [3:0] FT_PUSH_PROMISE = 4'h5;
	localparam logic [3:0] FT_H2_PING      = 4'h6;
	localparam logic [3:0] FT_GOAWAY       = 4'h7;
	localparam logic [3:0] FT_H2_WINDOW    = 4'h8;
	localparam logic [3:0] FT_H2_CONT      = 4'h9;
	localparam logic [3:0] FT_MAX_PUSH_ID  = 4'hD;

	// varint size codes (top two bits of the first byte)
	localparam logic [1:0] VS_1 = 2'd0;
	localparam logic [1:0] VS_2 = 2'd1;
	localparam logic [1:0] VS_4 = 2'd2;
	localparam logic [1:0] VS_8 = 2'd3;

	typedef enum logic [1:0] {
		PH_TYPE    = 2'd0,
		PH_LEN     = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		FC_DATA         = 4'd0,
		FC_HEADERS      = 4'd1,
		FC_CANCEL_PUSH  = 4'd2,
		FC_SETTINGS     = 4'd3,
		FC_PUSH_PROMISE = 4'd4,
		FC_GOAWAY       = 4'd5,
		FC_MAX_PUSH_ID  = 4'd6,
		FC_RESERVED     = 4'd7,
		FC_UNKNOWN      = 4'd8
	} frame_class_t;

	// one result as it travels from the parser to the output stage
	typedef struct packed {
		logic             kind;
		logic [VAL_W-1:0] rtype;
		logic [VAL_W-1:0] len;
		logic [7:0]       pbyte;
		logic             last;
	} hfd_rec_t;

	function automatic frame_class_t classify(input logic [VAL_W-1:0] t);
		frame_class_t c;
		c = FC_UNKNOWN;
		if (t[VAL_W-1:4] == '0) begin
			case (t[3:0])
				FT_DATA:         c = FC_DATA;
				FT_HEADERS:      c = FC_HEADERS;
				FT_CANCEL_PUSH:  c = FC_CANCEL_PUSH;
				FT_SETTINGS:     c = FC_SETTINGS;
				FT_PUSH_PROMISE: c = FC_PUSH_PROMISE;
				FT_GOAWAY:       c = FC_GOAWAY;
				FT_MAX_PUSH_ID:  c = FC_MAX_PUSH_ID;
				FT_H2_PRIORITY, FT_H2_PING, FT_H2_WINDOW, FT_H2_CONT: c = FC_RESERVED;
				default:         c = FC_UNKNOWN;
			endcase
		end
		return c;
	endfunction

endpackage

### rtl/http3_frame_deframer.sv
// Top level of the HTTP/3 frame deframer: parser, result queue and output stage.
// Depends on hfd_pkg, hfd_front, hfd_fifo and hfd_back.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------------
//   input    | in        | push / full        | data_byte, stream_start
//   result   | out       | pop / empty        | result_kind, frame_type, frame_class,
//            |           |                    | frame_length, payload_byte, last
//
// One byte per cycle is taken while the four-entry result queue has room.
// A result reaches the ports by way of the queue write, then the output register.
// Header bytes yield no result until the length varint completes.
// Reset clears parser state, queue pointers and the output valid flag.
// A stalled result side fills the queue; full then rises and holds input off.
module http3_frame_deframer import hfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       data_byte,
	input  logic             stream_start,
	output logic             empty,
	input  logic             pop,
	output logic             result_kind,
	output logic [VAL_W-1:0] frame_type,
	output logic [3:0]       frame_class,
	output logic [VAL_W-1:0] frame_length,
	output logic [7:0]       payload_byte,
	output logic             last
);

	logic     q_full, wr_en, rd_valid, rd_en;
	hfd_rec_t wr_rec, rd_rec;

	hfd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.q_full       (q_full),
		.data_byte    (data_byte),
		.stream_start (stream_start),
		.full         (full),
		.wr_en        (wr_en),
		.wr_rec       (wr_rec)
	);

	hfd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_rec   (wr_rec),
		.q_full   (q_full),
		.rd_valid (rd_valid),
		.rd_rec   (rd_rec),
		.rd_en    (rd_en)
	);

	hfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_valid     (rd_valid),
		.rd_rec       (rd_rec),
		.rd_en        (rd_en),
		.pop          (pop),
		.empty        (empty),
		.result_kind  (result_kind),
		.frame_type   (frame_type),
		.frame_class  (frame_class),
		.frame_length (frame_length),
		.payload_byte (payload_byte),
		.last         (last)
	);

endmodule

### rtl/hfd_front.sv
// Front end: takes stream bytes, collects the type and length varints, tracks payload.
// Emits one result record per frame header and one per payload byte. Depends on hfd_pkg.
module hfd_front import hfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  logic     q_full,
	input  logic [7:0] data_byte,
	input  logic     stream_start,
	output logic     full,
	output logic     wr_en,
	output hfd_rec_t wr_rec
);

	phase_t           phase_q, phase_n, phase_e;
	logic [2:0]       left_q, left_n, left_e, left_v;
	logic [VAL_W-1:0] acc_q, acc_n, acc_v;
	logic [VAL_W-1:0] held_q, held_n;
	logic [VAL_W-1:0] rem_q, rem_n, rem_e, rem_dec;
	logic             accept, done;

	assign full   = q_full;
	assign accept = push & ~q_full;

	// a fresh buffer drops any partial frame before this byte is parsed
	assign phase_e = stream_start ? PH_TYPE : phase_q;
	assign left_e  = stream_start ? 3'd0 : left_q;
	assign rem_e   = stream_start ? '0 : rem_q;
	assign rem_dec = (rem_e != '0) ? rem_e - VAL_W'(1) : rem_e;

	// varint collector
	always_comb begin
		if (left_e == 3'd0) begin
			acc_v = {{(VAL_W-6){1'b0}}, data_byte[5:0]};
			case (data_byte[7:6])
				VS_1:    left_v = 3'd0;
				VS_2:    left_v = 3'd1;
				VS_4:    left_v = 3'd3;
				VS_8:    left_v = 3'd7;
				default: left_v = 3'd0;
			endcase
		end else begin
			acc_v  = {acc_q[VAL_W-9:0], data_byte};
			left_v = left_e - 3'd1;
		end
	end
	assign done = (left_v == 3'd0);

	// next state
	always_comb begin
		phase_n = phase_q;
		left_n  = left_q;
		acc_n   = acc_q;
		held_n  = held_q;
		rem_n   = rem_q;
		if (accept) begin
			phase_n = phase_e;
			left_n  = left_e;
			held_n  = stream_start ? '0 : held_q;
			rem_n   = rem_e;
			case (phase_e)
				PH_PAYLOAD: begin
					rem_n = rem_dec;
					if (rem_dec == '0)
						phase_n = PH_TYPE;
				end
				PH_LEN: begin
					acc_n  = acc_v;
					left_n = left_v;
					if (done) begin
						acc_n = '0;
						if (acc_v == '0) begin
							phase_n = PH_TYPE;
							rem_n   = '0;
						end else begin
							phase_n = PH_PAYLOAD;
							rem_n   = acc_v;
						end
					end
				end
				default: begin
					acc_n  = acc_v;
					left_n = left_v;
					if (done) begin
						held_n  = acc_v;
						acc_n   = '0;
						phase_n = PH_LEN;
					end
				end
			endcase
		end
	end

	// result record
	always_comb begin
		wr_en  = 1'b0;
		wr_rec = '0;
		if (accept) begin
			case (phase_e)
				PH_PAYLOAD: begin
					wr_en        = 1'b1;
					wr_rec.kind  = RK_PAYLOAD;
					wr_rec.pbyte = data_byte;
					wr_rec.last  = (rem_e == VAL_W'(1));
				end
				PH_LEN: begin
					wr_en        = done;
					wr_rec.kind  = RK_HEADER;
					wr_rec.rtype = held_q;
					wr_rec.len   = acc_v;
					wr_rec.last  = (acc_v == '0);
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			left_q  <= 3'd0;
			acc_q   <= '0;
			held_q  <= '0;
			rem_q   <= '0;
		end else begin
			phase_q <= phase_n;
			left_q  <= left_n;
			acc_q   <= acc_n;
			held_q  <= held_n;
			rem_q   <= rem_n;
		end
	end

endmodule

### rtl/hfd_fifo.sv
// Short result queue between the parser and the output stage.
// Holds hfd_rec_t records; depends on hfd_pkg.
module hfd_fifo import hfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  hfd_rec_t wr_rec,
	output logic     q_full,
	output logic     rd_valid,
	output hfd_rec_t rd_rec,
	input  logic     rd_en
);

	hfd_rec_t         mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign q_full   = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_rec   = mem[rd_ptr_q];
	assign do_wr    = wr_en & ~q_full;
	assign do_rd    = rd_en & rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			mem[wr_ptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/hfd_back.sv
// Back end: classifies the frame type and holds the result on the output ports.
// Drains hfd_fifo; depends on hfd_pkg.
module hfd_back import hfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_valid,
	input  hfd_rec_t         rd_rec,
	output logic             rd_en,
	input  logic             pop,
	output logic             empty,
	output logic             result_kind,
	output logic [VAL_W-1:0] frame_type,
	output logic [3:0]       frame_class,
	output logic [VAL_W-1:0] frame_length,
	output logic [7:0]       payload_byte,
	output logic             last
);

	logic             valid_q;
	logic             kind_q, last_q;
	logic [VAL_W-1:0] rtype_q, len_q;
	logic [3:0]       class_q;
	logic [7:0]       pbyte_q;
	logic             is_hdr;

	// refill when the register is free or its result moves out this cycle
	assign rd_en  = rd_valid & (~valid_q | pop);
	assign is_hdr = (rd_rec.kind == RK_HEADER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (rd_en)
			valid_q <= 1'b1;
		else if (pop)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			kind_q  <= rd_rec.kind;
			rtype_q <= is_hdr ? rd_rec.rtype : '0;
			len_q   <= is_hdr ? rd_rec.len : '0;
			class_q <= is_hdr ? 4'(classify(rd_rec.rtype)) : 4'(FC_DATA);
			pbyte_q <= is_hdr ? 8'd0 : rd_rec.pbyte;
			last_q  <= rd_rec.last;
		end
	end

	assign empty        = ~valid_q;
	assign result_kind  = kind_q;
	assign frame_type   = rtype_q;
	assign frame_class  = class_q;
	assign frame_length = len_q;
	assign payload_byte = pbyte_q;
	assign last         = last_q;

endmodule

### rtl/hfd_checker.sv
// Port-level checks for the HTTP/3 frame deframer, bound to the top level.
// Depends on hfd_pkg.
module hfd_checker import hfd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input logic             result_kind,
	input logic [VAL_W-1:0] frame_type,
	input logic [3:0]       frame_class,
	input logic [VAL_W-1:0] frame_length,
	input logic [7:0]       payload_byte,
	input logic             last
);

	// a waiting result stays put until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result_kind) && $stable(frame_type)
			&& $stable(frame_length) && $stable(payload_byte) && $stable(last))
		else $error("result changed while waiting");

	// a header carries last exactly when its frame is empty
	a_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result_kind == RK_HEADER |-> last == (frame_length == '0))
		else $error("header last flag disagrees with length");

	// header-only fields read zero on payload results
	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result_kind == RK_PAYLOAD |->
			frame_type == '0 && frame_length == '0 && frame_class == 4'(FC_DATA))
		else $error("payload result has header fields set");

	// classification follows the raw type on headers, whose payload byte reads zero
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result_kind == RK_HEADER |->
			frame_class == 4'(classify(frame_type)) && payload_byte == 8'd0)
		else $error("header class does not match raw type");

	// a full queue always has a result waiting at the ports
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input held off with no result waiting");

endmodule

bind http3_frame_deframer hfd_checker u_hfd_checker (.*);
